// ===== design/sgc_pkg.sv =====
// Shared types, widths and codes of the swipe gesture classifier.
package sgc_pkg;

    localparam int LEVEL_BITS = 8;
    localparam int THR_W      = 8;
    localparam int SENS_W     = 7;
    localparam int GEST_W     = 3;
    localparam int DIFF_W     = LEVEL_BITS + 1;
    localparam int TOT_W      = LEVEL_BITS + 2;
    localparam int LVL_CMP_W  = (LEVEL_BITS > THR_W) ? LEVEL_BITS : THR_W;
    localparam int CMP_W      = ((TOT_W > SENS_W) ? TOT_W : SENS_W) + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET   = THR_W'(40);
    localparam logic [SENS_W-1:0] SENSITIVITY_RESET = SENS_W'(80);
    localparam logic [SENS_W-1:0] FULL_PERCENT      = SENS_W'(100);

    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_SENSITIVITY = 1'b1;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [GEST_W-1:0] G_NONE  = GEST_W'(0);
    localparam logic [GEST_W-1:0] G_LEFT  = GEST_W'(1);
    localparam logic [GEST_W-1:0] G_RIGHT = GEST_W'(2);
    localparam logic [GEST_W-1:0] G_DOWN  = GEST_W'(3);
    localparam logic [GEST_W-1:0] G_UP    = GEST_W'(4);

    typedef struct packed {
        logic                  command;
        logic [LEVEL_BITS-1:0] up_level;
        logic [LEVEL_BITS-1:0] down_level;
        logic [LEVEL_BITS-1:0] left_level;
        logic [LEVEL_BITS-1:0] right_level;
    } t_in_item;

    typedef struct packed {
        logic [GEST_W-1:0] gesture;
        logic              hand_present;
    } t_out_item;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SENS_W-1:0] sensitivity;
    } t_cfg;

endpackage

// ===== design/sgc_cfg_regs.sv =====
// Configuration register file of the swipe gesture classifier behind an APB-style port.
module sgc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sgc_pkg::ADDR_W-1:0] paddr,
    input  logic [sgc_pkg::DATA_W-1:0] pwdata,
    output logic [sgc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output sgc_pkg::t_cfg              o_cfg
);

    logic [sgc_pkg::THR_W-1:0]  r_threshold;
    logic [sgc_pkg::SENS_W-1:0] r_sensitivity;
    logic [sgc_pkg::SENS_W-1:0] w_sens_sat;
    logic                       w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;

    always_comb begin
        w_sens_sat = pwdata[sgc_pkg::SENS_W-1:0];
        if (w_sens_sat > sgc_pkg::FULL_PERCENT) begin
            w_sens_sat = sgc_pkg::FULL_PERCENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= sgc_pkg::THRESHOLD_RESET;
            r_sensitivity <= sgc_pkg::SENSITIVITY_RESET;
        end else if (w_write) begin
            unique case (paddr[2])
                sgc_pkg::REG_THRESHOLD:   r_threshold   <= pwdata[sgc_pkg::THR_W-1:0];
                sgc_pkg::REG_SENSITIVITY: r_sensitivity <= w_sens_sat;
                default:                  r_threshold   <= r_threshold;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sgc_pkg::REG_THRESHOLD:   prdata = sgc_pkg::DATA_W'(r_threshold);
            sgc_pkg::REG_SENSITIVITY: prdata = sgc_pkg::DATA_W'(r_sensitivity);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.threshold   = r_threshold;
    assign o_cfg.sensitivity = r_sensitivity;

endmodule

// ===== design/sgc_tracker.sv =====
// Hand tracking state and swipe classification for one transaction per cycle in which i_step is high.
module sgc_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  sgc_pkg::t_in_item  i_item,
    input  sgc_pkg::t_cfg      i_cfg,
    output sgc_pkg::t_out_item o_result
);

    logic                               r_awaiting;
    logic                               r_seen;
    logic signed [sgc_pkg::DIFF_W-1:0]  r_cur_dx;
    logic signed [sgc_pkg::DIFF_W-1:0]  r_cur_dy;
    logic signed [sgc_pkg::DIFF_W-1:0]  r_entry_dx;
    logic signed [sgc_pkg::DIFF_W-1:0]  r_entry_dy;
    logic [sgc_pkg::GEST_W-1:0]         r_latched;

    logic                               n_awaiting;
    logic                               n_seen;
    logic signed [sgc_pkg::DIFF_W-1:0]  n_cur_dx;
    logic signed [sgc_pkg::DIFF_W-1:0]  n_cur_dy;
    logic signed [sgc_pkg::DIFF_W-1:0]  n_entry_dx;
    logic signed [sgc_pkg::DIFF_W-1:0]  n_entry_dy;
    logic [sgc_pkg::GEST_W-1:0]         n_latched;

    logic [sgc_pkg::LVL_CMP_W-1:0]      w_th;
    logic                               w_empty;
    logic signed [sgc_pkg::DIFF_W-1:0]  w_dx;
    logic signed [sgc_pkg::DIFF_W-1:0]  w_dy;
    logic signed [sgc_pkg::CMP_W-1:0]   w_tx;
    logic signed [sgc_pkg::CMP_W-1:0]   w_ty;
    logic signed [sgc_pkg::CMP_W-1:0]   w_margin;
    logic [sgc_pkg::SENS_W-1:0]         w_margin_u;

    assign w_th    = sgc_pkg::LVL_CMP_W'(i_cfg.threshold);
    assign w_empty = (sgc_pkg::LVL_CMP_W'(i_item.up_level) < w_th)
                  && (sgc_pkg::LVL_CMP_W'(i_item.down_level) < w_th)
                  && (sgc_pkg::LVL_CMP_W'(i_item.left_level) < w_th)
                  && (sgc_pkg::LVL_CMP_W'(i_item.right_level) < w_th);

    assign w_dx = signed'({1'b0, i_item.right_level}) - signed'({1'b0, i_item.left_level});
    assign w_dy = signed'({1'b0, i_item.up_level}) - signed'({1'b0, i_item.down_level});

    assign w_tx       = sgc_pkg::CMP_W'(r_entry_dx) - sgc_pkg::CMP_W'(r_cur_dx);
    assign w_ty       = sgc_pkg::CMP_W'(r_entry_dy) - sgc_pkg::CMP_W'(r_cur_dy);
    assign w_margin_u = sgc_pkg::FULL_PERCENT - i_cfg.sensitivity;
    assign w_margin   = signed'(sgc_pkg::CMP_W'(w_margin_u));

    always_comb begin
        n_awaiting = r_awaiting;
        n_seen     = r_seen;
        n_cur_dx   = r_cur_dx;
        n_cur_dy   = r_cur_dy;
        n_entry_dx = r_entry_dx;
        n_entry_dy = r_entry_dy;
        n_latched  = r_latched;
        o_result.gesture      = r_latched;
        o_result.hand_present = r_seen && !r_awaiting;

        if (i_item.command == sgc_pkg::CMD_READ) begin
            n_latched = sgc_pkg::G_NONE;
        end else begin
            n_seen = 1'b1;
            if (w_empty) begin
                n_awaiting = 1'b1;
                if ((r_entry_dx != '0) || (r_entry_dy != '0)) begin
                    priority if (w_ty > w_margin) begin
                        n_latched = sgc_pkg::G_UP;
                    end else if (w_ty < -w_margin) begin
                        n_latched = sgc_pkg::G_DOWN;
                    end else if (w_tx > w_margin) begin
                        n_latched = sgc_pkg::G_RIGHT;
                    end else if (w_tx < -w_margin) begin
                        n_latched = sgc_pkg::G_LEFT;
                    end
                    n_cur_dx   = '0;
                    n_cur_dy   = '0;
                    n_entry_dx = '0;
                    n_entry_dy = '0;
                end
            end else begin
                n_cur_dx = w_dx;
                n_cur_dy = w_dy;
                if (r_awaiting) begin
                    n_awaiting = 1'b0;
                    n_entry_dx = w_dx;
                    n_entry_dy = w_dy;
                end
            end
            o_result.gesture      = n_latched;
            o_result.hand_present = !n_awaiting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_seen     <= 1'b0;
            r_cur_dx   <= '0;
            r_cur_dy   <= '0;
            r_entry_dx <= '0;
            r_entry_dy <= '0;
            r_latched  <= sgc_pkg::G_NONE;
        end else if (i_step) begin
            r_awaiting <= n_awaiting;
            r_seen     <= n_seen;
            r_cur_dx   <= n_cur_dx;
            r_cur_dy   <= n_cur_dy;
            r_entry_dx <= n_entry_dx;
            r_entry_dy <= n_entry_dy;
            r_latched  <= n_latched;
        end
    end

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.command == sgc_pkg::CMD_READ) |=> r_latched == sgc_pkg::G_NONE)
        else $error("Latched gesture not cleared by a read.");

    a_idle_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> (r_entry_dx == '0) && (r_entry_dy == '0))
        else $error("Entry differences kept while no hand is present.");

    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched <= sgc_pkg::G_UP)
        else $error("Latched gesture holds an undefined code.");

endmodule

// ===== design/swipe_gesture_classifier.sv =====
// Top level of the swipe gesture classifier: input register, tracker and result register.
//
// Usage: each input transaction carries either one photodiode dataset (command push) or
// a read command that returns and clears the latched gesture. Every input transaction
// yields exactly one output transaction with the latched gesture and the hand flag.
// An accepted transaction waits in the input register until the result register is free,
// is evaluated by the tracker and lands in the result register, which drives o_out_valid.
// One transaction can be accepted every cycle while o_in_stall is low; the tracker state
// updates as each result is registered, so back-to-back datasets see each other's effect.
// When the receiver asserts i_out_stall a full result register holds; the input register
// still takes one more transaction, and o_in_stall rises only while both are full.
// Reset clears the valid flags of both registers, all tracking state and the latched
// gesture, and loads threshold 40 and sensitivity 80. The APB-style port is always
// ready and should be written only while no transaction is in flight.
module swipe_gesture_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  sgc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output sgc_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sgc_pkg::ADDR_W-1:0] paddr,
    input  logic [sgc_pkg::DATA_W-1:0] pwdata,
    output logic [sgc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sgc_pkg::t_cfg      w_cfg;
    sgc_pkg::t_in_item  r_in_data;
    logic               r_in_valid;
    sgc_pkg::t_out_item r_out_data;
    logic               r_out_valid;
    sgc_pkg::t_out_item w_result;
    logic               w_advance;
    logic               w_step;
    logic               w_in_accept;

    sgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sgc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_data),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_advance   = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_advance;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("Input stalled with a free register.");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("Evaluated transaction produced no result.");

endmodule
